[rtl/core/grs_pkg.sv]
// Shared types, codes and a helper function for the grid robot stepper.
`timescale 1ns / 1ps

package grs_pkg;

    localparam int ROBOT_SLOTS_DEF = 4;
    localparam int NUM_CAND = 5;
    localparam logic [2:0] SAFE_DIST_RST = 3'd2;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } opcode_t;

    typedef enum logic [2:0] {
        ST_DIRECT    = 3'd0,
        ST_ALTERNATE = 3'd1,
        ST_YIELD     = 3'd2,
        ST_BLOCKED   = 3'd3,
        ST_IDLE      = 3'd4,
        ST_LOADED    = 3'd5
    } status_t;

    typedef struct packed {
        opcode_t            opcode;
        logic [1:0]         robot_index;
        logic signed [7:0]  load_x;
        logic signed [7:0]  load_y;
        logic signed [7:0]  load_goal_x;
        logic signed [7:0]  load_goal_y;
    } req_t;

    typedef struct packed {
        logic [1:0]         out_index;
        logic signed [7:0]  new_x;
        logic signed [7:0]  new_y;
        status_t            status;
        logic               reached;
    } rsp_t;

    typedef struct packed {
        logic close;
        logic lower;
        logic outside;
    } probe_flags_t;

    typedef struct packed {
        logic               wr_pos;
        logic               wr_goal;
        logic               wr_active;
        logic               active;
        logic signed [7:0]  row;
        logic signed [7:0]  col;
        logic signed [7:0]  goal_row;
        logic signed [7:0]  goal_col;
    } slot_upd_t;

    // Square of a 3-bit magnitude.
    function automatic logic [5:0] square3(input logic [2:0] v);
        logic [5:0] sq;
        case (v)
            3'd0:    sq = 6'd0;
            3'd1:    sq = 6'd1;
            3'd2:    sq = 6'd4;
            3'd3:    sq = 6'd9;
            3'd4:    sq = 6'd16;
            3'd5:    sq = 6'd25;
            3'd6:    sq = 6'd36;
            3'd7:    sq = 6'd49;
            default: sq = 6'd0;
        endcase
        return sq;
    endfunction

endpackage

[rtl/core/grs_cell_probe.sv]
// Checks one candidate cell against the coordinate range and all other active robots.
`timescale 1ns / 1ps

module grs_cell_probe #(
    parameter int ROBOT_SLOTS = grs_pkg::ROBOT_SLOTS_DEF,
    localparam int SLOT_W = $clog2(ROBOT_SLOTS)
) (
    input  logic signed [8:0]       cell_row,
    input  logic signed [8:0]       cell_col,
    input  logic [SLOT_W-1:0]       self_slot,
    input  logic signed [7:0]       pos_row [ROBOT_SLOTS],
    input  logic signed [7:0]       pos_col [ROBOT_SLOTS],
    input  logic [ROBOT_SLOTS-1:0]  active,
    input  logic [5:0]              limit,
    output grs_pkg::probe_flags_t   flags
);

    logic [ROBOT_SLOTS-1:0] hit;
    logic [ROBOT_SLOTS-1:0] hit_lower;

    // A difference of seven or more in either axis always reaches the largest limit,
    // so each magnitude saturates at seven before it is squared.
    for (genvar j = 0; j < ROBOT_SLOTS; j++)
    begin : g_other
        logic signed [9:0] d_row;
        logic signed [9:0] d_col;
        logic [9:0]        a_row;
        logic [9:0]        a_col;
        logic [2:0]        q_row;
        logic [2:0]        q_col;
        logic [6:0]        dist_sq;

        assign d_row = 10'(cell_row) - 10'(pos_row[j]);
        assign d_col = 10'(cell_col) - 10'(pos_col[j]);
        assign a_row = d_row[9] ? (~d_row + 10'd1) : d_row;
        assign a_col = d_col[9] ? (~d_col + 10'd1) : d_col;
        assign q_row = (a_row > 10'd6) ? 3'd7 : a_row[2:0];
        assign q_col = (a_col > 10'd6) ? 3'd7 : a_col[2:0];
        assign dist_sq = {1'b0, grs_pkg::square3(q_row)} + {1'b0, grs_pkg::square3(q_col)};
        assign hit[j] = active[j] && (SLOT_W'(j) != self_slot) && (dist_sq < {1'b0, limit});
        assign hit_lower[j] = hit[j] && (SLOT_W'(j) < self_slot);
    end

    assign flags.close   = |hit;
    assign flags.lower   = |hit_lower;
    assign flags.outside = (cell_row > 9'sd127) || (cell_row < -9'sd128) ||
                           (cell_col > 9'sd127) || (cell_col < -9'sd128);

endmodule

[rtl/core/grs_step_eval.sv]
// Decides the outcome of one request and the update of the addressed robot slot.
`timescale 1ns / 1ps

module grs_step_eval #(
    parameter int ROBOT_SLOTS = grs_pkg::ROBOT_SLOTS_DEF,
    localparam int SLOT_W = $clog2(ROBOT_SLOTS)
) (
    input  grs_pkg::req_t           req,
    input  logic                    slot_ok,
    input  logic [SLOT_W-1:0]       self_slot,
    input  logic signed [7:0]       pos_row [ROBOT_SLOTS],
    input  logic signed [7:0]       pos_col [ROBOT_SLOTS],
    input  logic signed [7:0]       goal_row [ROBOT_SLOTS],
    input  logic signed [7:0]       goal_col [ROBOT_SLOTS],
    input  logic [ROBOT_SLOTS-1:0]  active,
    input  logic [5:0]              limit,
    output grs_pkg::rsp_t           rsp,
    output grs_pkg::slot_upd_t      upd
);

    logic signed [7:0] cur_row;
    logic signed [7:0] cur_col;
    logic signed [7:0] cur_goal_row;
    logic signed [7:0] cur_goal_col;
    logic              cur_active;
    logic              at_goal;
    logic signed [8:0] row9;
    logic signed [8:0] col9;
    logic signed [8:0] dx9;
    logic signed [8:0] dy9;

    logic signed [8:0]     cand_row [grs_pkg::NUM_CAND];
    logic signed [8:0]     cand_col [grs_pkg::NUM_CAND];
    grs_pkg::probe_flags_t cand_flags [grs_pkg::NUM_CAND];
    logic [grs_pkg::NUM_CAND-1:0] cand_safe;

    logic                  moved;
    grs_pkg::status_t      move_status;
    logic signed [7:0]     mv_row;
    logic signed [7:0]     mv_col;

    assign cur_row      = pos_row[self_slot];
    assign cur_col      = pos_col[self_slot];
    assign cur_goal_row = goal_row[self_slot];
    assign cur_goal_col = goal_col[self_slot];
    assign cur_active   = active[self_slot];
    assign at_goal      = (cur_row == cur_goal_row) && (cur_col == cur_goal_col);

    assign row9 = 9'(cur_row);
    assign col9 = 9'(cur_col);
    assign dx9  = (cur_goal_row > cur_row) ? 9'sd1 : ((cur_goal_row < cur_row) ? -9'sd1 : 9'sd0);
    assign dy9  = (cur_goal_col > cur_col) ? 9'sd1 : ((cur_goal_col < cur_col) ? -9'sd1 : 9'sd0);

    // The direct cell first, then the four alternates in the order they are tried.
    assign cand_row[0] = row9 + dx9;
    assign cand_col[0] = col9 + dy9;
    assign cand_row[1] = row9 + dx9;
    assign cand_col[1] = col9;
    assign cand_row[2] = row9;
    assign cand_col[2] = col9 + dy9;
    assign cand_row[3] = row9 - dx9;
    assign cand_col[3] = col9;
    assign cand_row[4] = row9;
    assign cand_col[4] = col9 - dy9;

    for (genvar k = 0; k < grs_pkg::NUM_CAND; k++)
    begin : g_cand
        grs_cell_probe #(
            .ROBOT_SLOTS(ROBOT_SLOTS)
        ) u_probe (
            .cell_row  (cand_row[k]),
            .cell_col  (cand_col[k]),
            .self_slot (self_slot),
            .pos_row   (pos_row),
            .pos_col   (pos_col),
            .active    (active),
            .limit     (limit),
            .flags     (cand_flags[k])
        );

        assign cand_safe[k] = !cand_flags[k].close && !cand_flags[k].lower &&
                              !cand_flags[k].outside;
    end

    always_comb
    begin
        moved       = 1'b1;
        move_status = grs_pkg::ST_DIRECT;
        mv_row      = cand_row[0][7:0];
        mv_col      = cand_col[0][7:0];
        if (cand_safe[0])
        begin
            move_status = grs_pkg::ST_DIRECT;
        end
        else if (cand_flags[0].lower)
        begin
            moved       = 1'b0;
            move_status = grs_pkg::ST_YIELD;
        end
        else if (cand_safe[1])
        begin
            move_status = grs_pkg::ST_ALTERNATE;
            mv_row      = cand_row[1][7:0];
            mv_col      = cand_col[1][7:0];
        end
        else if (cand_safe[2])
        begin
            move_status = grs_pkg::ST_ALTERNATE;
            mv_row      = cand_row[2][7:0];
            mv_col      = cand_col[2][7:0];
        end
        else if (cand_safe[3])
        begin
            move_status = grs_pkg::ST_ALTERNATE;
            mv_row      = cand_row[3][7:0];
            mv_col      = cand_col[3][7:0];
        end
        else if (cand_safe[4])
        begin
            move_status = grs_pkg::ST_ALTERNATE;
            mv_row      = cand_row[4][7:0];
            mv_col      = cand_col[4][7:0];
        end
        else
        begin
            moved       = 1'b0;
            move_status = grs_pkg::ST_BLOCKED;
        end
    end

    always_comb
    begin
        rsp.out_index = req.robot_index;
        rsp.new_x     = 8'sd0;
        rsp.new_y     = 8'sd0;
        rsp.status    = grs_pkg::ST_IDLE;
        rsp.reached   = 1'b0;

        upd.wr_pos    = 1'b0;
        upd.wr_goal   = 1'b0;
        upd.wr_active = 1'b0;
        upd.active    = 1'b0;
        upd.row       = cur_row;
        upd.col       = cur_col;
        upd.goal_row  = req.load_goal_x;
        upd.goal_col  = req.load_goal_y;

        if (slot_ok)
        begin
            case (req.opcode)
                grs_pkg::OP_LOAD:
                begin
                    upd.wr_pos    = 1'b1;
                    upd.wr_goal   = 1'b1;
                    upd.wr_active = 1'b1;
                    upd.active    = 1'b1;
                    upd.row       = req.load_x;
                    upd.col       = req.load_y;
                    rsp.new_x     = req.load_x;
                    rsp.new_y     = req.load_y;
                    rsp.status    = grs_pkg::ST_LOADED;
                end
                grs_pkg::OP_STEP:
                begin
                    rsp.new_x = cur_row;
                    rsp.new_y = cur_col;
                    if (cur_active)
                    begin
                        if (at_goal)
                        begin
                            upd.wr_active = 1'b1;
                            rsp.reached   = 1'b1;
                        end
                        else
                        begin
                            rsp.status = move_status;
                            if (moved)
                            begin
                                upd.wr_pos = 1'b1;
                                upd.row    = mv_row;
                                upd.col    = mv_col;
                                rsp.new_x  = mv_row;
                                rsp.new_y  = mv_col;
                                if ((mv_row == cur_goal_row) && (mv_col == cur_goal_col))
                                begin
                                    upd.wr_active = 1'b1;
                                    rsp.reached   = 1'b1;
                                end
                            end
                        end
                    end
                end
                default:
                begin
                    rsp.status = grs_pkg::ST_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/core/grid_robot_step_with_collision_yield_core.sv]
// Top level of the grid robot stepper: request and response registers and the robot table.
`timescale 1ns / 1ps

// Usage:
// A request arrives on req_valid/req_data and is taken at a rising edge where req_valid is
// high and req_stall is low. A load request writes one robot's position and goal and marks
// it active; a step request moves one robot at most a single cell, yielding to lower-numbered
// robots and otherwise trying alternate cells when the direct cell toward its goal is unsafe.
// Every request produces exactly one response on rsp_valid/rsp_data, taken at an edge where
// rsp_valid is high and rsp_stall is low. A request passes through the request register,
// then the response register. One request is accepted every cycle while rsp_stall is low;
// all distance checks for the five candidate cells run in parallel between those two
// registers, and the robot table is updated in the same cycle. While a valid response is
// stalled it holds, the request register keeps its request, and req_stall rises once that
// register is occupied. The user must write the safe distance with cfg_we/cfg_data only
// while no request is in flight; the block does not enforce it. Reset clears every robot
// slot to inactive at the origin and sets the safe distance to two.
module grid_robot_step_with_collision_yield_core #(
    parameter int ROBOT_SLOTS = grs_pkg::ROBOT_SLOTS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  grs_pkg::req_t  req_data,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output grs_pkg::rsp_t  rsp_data,
    input  logic           cfg_we,
    input  logic [2:0]     cfg_data
);

    localparam int SLOT_W = $clog2(ROBOT_SLOTS);

    grs_pkg::req_t          req_reg;
    logic                   req_valid_reg;
    logic                   req_valid_next;
    grs_pkg::rsp_t          rsp_reg;
    logic                   rsp_valid_reg;
    logic                   rsp_valid_next;
    logic [2:0]             safe_dist_reg;
    logic [2:0]             safe_dist_next;

    logic signed [7:0]      pos_row_reg [ROBOT_SLOTS];
    logic signed [7:0]      pos_col_reg [ROBOT_SLOTS];
    logic signed [7:0]      goal_row_reg [ROBOT_SLOTS];
    logic signed [7:0]      goal_col_reg [ROBOT_SLOTS];
    logic [ROBOT_SLOTS-1:0] active_reg;
    logic signed [7:0]      pos_row_next [ROBOT_SLOTS];
    logic signed [7:0]      pos_col_next [ROBOT_SLOTS];
    logic signed [7:0]      goal_row_next [ROBOT_SLOTS];
    logic signed [7:0]      goal_col_next [ROBOT_SLOTS];
    logic [ROBOT_SLOTS-1:0] active_next;

    logic                   advance;
    logic                   fire;
    logic                   req_take;
    logic                   slot_ok;
    logic [SLOT_W-1:0]      self_slot;
    logic [5:0]             limit;
    grs_pkg::rsp_t          rsp_calc;
    grs_pkg::slot_upd_t     upd;

    assign advance   = !rsp_valid_reg || !rsp_stall;
    assign fire      = req_valid_reg && advance;
    assign req_stall = req_valid_reg && !advance;
    assign req_take  = req_valid && !req_stall;

    assign slot_ok   = 32'(req_reg.robot_index) < 32'(ROBOT_SLOTS);
    assign self_slot = SLOT_W'(req_reg.robot_index);
    assign limit     = grs_pkg::square3(safe_dist_reg);

    grs_step_eval #(
        .ROBOT_SLOTS(ROBOT_SLOTS)
    ) u_eval (
        .req       (req_reg),
        .slot_ok   (slot_ok),
        .self_slot (self_slot),
        .pos_row   (pos_row_reg),
        .pos_col   (pos_col_reg),
        .goal_row  (goal_row_reg),
        .goal_col  (goal_col_reg),
        .active    (active_reg),
        .limit     (limit),
        .rsp       (rsp_calc),
        .upd       (upd)
    );

    always_comb
    begin
        req_valid_next = req_valid_reg;
        rsp_valid_next = rsp_valid_reg;
        safe_dist_next = safe_dist_reg;
        pos_row_next   = pos_row_reg;
        pos_col_next   = pos_col_reg;
        goal_row_next  = goal_row_reg;
        goal_col_next  = goal_col_reg;
        active_next    = active_reg;

        if (cfg_we)
        begin
            safe_dist_next = cfg_data;
        end

        if (advance)
        begin
            rsp_valid_next = req_valid_reg;
            req_valid_next = 1'b0;
        end
        if (req_take)
        begin
            req_valid_next = 1'b1;
        end

        if (fire)
        begin
            if (upd.wr_pos)
            begin
                pos_row_next[self_slot] = upd.row;
                pos_col_next[self_slot] = upd.col;
            end
            if (upd.wr_goal)
            begin
                goal_row_next[self_slot] = upd.goal_row;
                goal_col_next[self_slot] = upd.goal_col;
            end
            if (upd.wr_active)
            begin
                active_next[self_slot] = upd.active;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            safe_dist_reg <= grs_pkg::SAFE_DIST_RST;
            active_reg    <= '0;
            for (int i = 0; i < ROBOT_SLOTS; i++)
            begin
                pos_row_reg[i]  <= 8'sd0;
                pos_col_reg[i]  <= 8'sd0;
                goal_row_reg[i] <= 8'sd0;
                goal_col_reg[i] <= 8'sd0;
            end
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            rsp_valid_reg <= rsp_valid_next;
            safe_dist_reg <= safe_dist_next;
            active_reg    <= active_next;
            pos_row_reg   <= pos_row_next;
            pos_col_reg   <= pos_col_next;
            goal_row_reg  <= goal_row_next;
            goal_col_reg  <= goal_col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            req_reg <= req_data;
        end
        if (fire)
        begin
            rsp_reg <= rsp_calc;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

endmodule

[sim/tb_grid_robot_step_with_collision_yield_core.sv]
// Self-checking testbench for the grid robot stepper: directed and random requests.
`timescale 1ns / 1ps

module tb_grid_robot_step_with_collision_yield_core;

    localparam int SLOTS = grs_pkg::ROBOT_SLOTS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 1880;
    localparam int PHASES = 8;
    localparam int HOLD_CYCLES = 80;

    class robot_fleet_tracker;
        int row_at[SLOTS];
        int col_at[SLOTS];
        int goal_row_at[SLOTS];
        int goal_col_at[SLOTS];
        bit live[SLOTS];
        int spacing;
        grs_pkg::rsp_t due_rsps[$];
        int mismatches;

        function new();
            foreach (live[i])
            begin
                row_at[i] = 0;
                col_at[i] = 0;
                goal_row_at[i] = 0;
                goal_col_at[i] = 0;
                live[i] = 1'b0;
            end
            spacing = grs_pkg::SAFE_DIST_RST;
            mismatches = 0;
        endfunction

        function void set_spacing(logic [2:0] v);
            spacing = v;
        endfunction

        function int pending();
            return due_rsps.size();
        endfunction

        function int toward(int v);
            return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
        endfunction

        function grs_pkg::probe_flags_t hazard(int self, int r, int c);
            grs_pkg::probe_flags_t f;
            int lim;
            int a;
            int b;
            f = '0;
            lim = spacing * spacing;
            if (r < -128 || r > 127 || c < -128 || c > 127)
                f.outside = 1'b1;
            for (int j = 0; j < SLOTS; j++)
            begin
                if (j != self && live[j])
                begin
                    a = r - row_at[j];
                    b = c - col_at[j];
                    if (a * a + b * b < lim)
                    begin
                        f.close = 1'b1;
                        if (j < self)
                            f.lower = 1'b1;
                    end
                end
            end
            return f;
        endfunction

        function void note_request(grs_pkg::req_t q);
            grs_pkg::rsp_t e;
            int id;
            int x;
            int y;
            int dx;
            int dy;
            int alt_r[4];
            int alt_c[4];
            grs_pkg::probe_flags_t f;
            id = q.robot_index;
            e.out_index = q.robot_index;
            e.status = grs_pkg::ST_IDLE;
            e.reached = 1'b0;
            if (q.opcode == grs_pkg::OP_LOAD)
            begin
                row_at[id] = q.load_x;
                col_at[id] = q.load_y;
                goal_row_at[id] = q.load_goal_x;
                goal_col_at[id] = q.load_goal_y;
                live[id] = 1'b1;
                e.status = grs_pkg::ST_LOADED;
            end
            else if (live[id])
            begin
                x = row_at[id];
                y = col_at[id];
                if (x == goal_row_at[id] && y == goal_col_at[id])
                begin
                    live[id] = 1'b0;
                    e.reached = 1'b1;
                end
                else
                begin
                    dx = toward(goal_row_at[id] - x);
                    dy = toward(goal_col_at[id] - y);
                    f = hazard(id, x + dx, y + dy);
                    if (f == '0)
                    begin
                        row_at[id] = x + dx;
                        col_at[id] = y + dy;
                        e.status = grs_pkg::ST_DIRECT;
                    end
                    else if (f.lower)
                    begin
                        e.status = grs_pkg::ST_YIELD;
                    end
                    else
                    begin
                        alt_r = '{dx, 0, -dx, 0};
                        alt_c = '{0, dy, 0, -dy};
                        e.status = grs_pkg::ST_BLOCKED;
                        for (int k = 0; k < 4; k++)
                        begin
                            if (e.status == grs_pkg::ST_BLOCKED &&
                                hazard(id, x + alt_r[k], y + alt_c[k]) == '0)
                            begin
                                row_at[id] = x + alt_r[k];
                                col_at[id] = y + alt_c[k];
                                e.status = grs_pkg::ST_ALTERNATE;
                            end
                        end
                    end
                    if ((e.status == grs_pkg::ST_DIRECT ||
                         e.status == grs_pkg::ST_ALTERNATE) &&
                        row_at[id] == goal_row_at[id] && col_at[id] == goal_col_at[id])
                    begin
                        live[id] = 1'b0;
                        e.reached = 1'b1;
                    end
                end
            end
            e.new_x = 8'(row_at[id]);
            e.new_y = 8'(col_at[id]);
            due_rsps.push_back(e);
        endfunction

        function void check_response(grs_pkg::rsp_t got);
            grs_pkg::rsp_t e;
            if (due_rsps.size() == 0)
            begin
                $error("response for slot %0d arrived with none expected", got.out_index);
                mismatches++;
                return;
            end
            e = due_rsps.pop_front();
            if (got.out_index !== e.out_index)
            begin
                $error("out_index expected %0d got %0d", e.out_index, got.out_index);
                mismatches++;
            end
            if (got.new_x !== e.new_x)
            begin
                $error("new_x expected %0d got %0d", e.new_x, got.new_x);
                mismatches++;
            end
            if (got.new_y !== e.new_y)
            begin
                $error("new_y expected %0d got %0d", e.new_y, got.new_y);
                mismatches++;
            end
            if (got.status !== e.status)
            begin
                $error("status expected %0d got %0d", e.status, got.status);
                mismatches++;
            end
            if (got.reached !== e.reached)
            begin
                $error("reached expected %0d got %0d", e.reached, got.reached);
                mismatches++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    grs_pkg::req_t req_data;
    logic rsp_valid;
    logic rsp_stall;
    grs_pkg::rsp_t rsp_data;
    logic cfg_we;
    logic [2:0] cfg_data;

    robot_fleet_tracker fleet;
    int cycles;
    int tx_idle_pct;
    int rx_idle_pct;
    bit hold_off;

    grid_robot_step_with_collision_yield_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        cycles = 0;
    end

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            fleet.check_response(rsp_data);
    end

    initial
    begin
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                rsp_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_off = 1'b0;
                rsp_stall = 1'b0;
            end
            else if (rx_idle_pct != 0 && $urandom_range(99) < rx_idle_pct)
            begin
                rsp_stall = 1'b1;
                repeat ($urandom_range(1, 18)) @(negedge clk);
                rsp_stall = 1'b0;
            end
        end
    end

    function automatic logic signed [7:0] clamp8(int v);
        return (v > 127) ? 8'sd127 : ((v < -128) ? -8'sd128 : 8'(v));
    endfunction

    function automatic grs_pkg::req_t random_request(int cx, int cy);
        grs_pkg::req_t q;
        int roll;
        roll = $urandom_range(99);
        q.robot_index = 2'($urandom_range(SLOTS - 1));
        q.load_x = 8'($urandom);
        q.load_y = 8'($urandom);
        q.load_goal_x = 8'($urandom);
        q.load_goal_y = 8'($urandom);
        if (roll < 10)
        begin
            q.opcode = ($urandom_range(1) == 1) ? grs_pkg::OP_STEP : grs_pkg::OP_LOAD;
        end
        else if (roll < 38)
        begin
            q.opcode = grs_pkg::OP_LOAD;
            q.load_x = clamp8(cx + int'($urandom_range(12)) - 6);
            q.load_y = clamp8(cy + int'($urandom_range(12)) - 6);
            q.load_goal_x = clamp8(cx + int'($urandom_range(24)) - 12);
            q.load_goal_y = clamp8(cy + int'($urandom_range(24)) - 12);
        end
        else
        begin
            q.opcode = grs_pkg::OP_STEP;
        end
        return q;
    endfunction

    task automatic push_request(input grs_pkg::req_t q);
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
        begin
            req_valid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        req_valid = 1'b1;
        req_data = q;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        fleet.note_request(q);
        @(negedge clk);
    endtask

    task automatic load_robot(input int id, input int x, input int y, input int gx,
                              input int gy);
        grs_pkg::req_t q;
        q.opcode = grs_pkg::OP_LOAD;
        q.robot_index = 2'(id);
        q.load_x = 8'(x);
        q.load_y = 8'(y);
        q.load_goal_x = 8'(gx);
        q.load_goal_y = 8'(gy);
        push_request(q);
    endtask

    task automatic step_robot(input int id);
        grs_pkg::req_t q;
        q.opcode = grs_pkg::OP_STEP;
        q.robot_index = 2'(id);
        q.load_x = 8'($urandom);
        q.load_y = 8'($urandom);
        q.load_goal_x = 8'($urandom);
        q.load_goal_y = 8'($urandom);
        push_request(q);
    endtask

    task automatic drain_requests();
        req_valid = 1'b0;
        while (fleet.pending() != 0) @(negedge clk);
    endtask

    task automatic program_spacing(input logic [2:0] v);
        drain_requests();
        repeat (4) @(negedge clk);
        cfg_we = 1'b1;
        cfg_data = v;
        @(negedge clk);
        cfg_we = 1'b0;
        fleet.set_spacing(v);
    endtask

    initial
    begin
        logic [2:0] spacing_plan[PHASES];
        int cx;
        int cy;
        int per_phase;
        fleet = new();
        spacing_plan = '{3'd1, 3'd7, 3'd0, 3'd3, 3'd5, 3'd4, 3'd6, 3'd2};
        req_valid = 1'b0;
        req_data = '0;
        cfg_we = 1'b0;
        cfg_data = grs_pkg::SAFE_DIST_RST;
        hold_off = 1'b0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        program_spacing(3'd2);
        tx_idle_pct = 25;
        rx_idle_pct = 25;
        step_robot(0);
        load_robot(0, 127, 127, -128, -128);
        load_robot(1, -128, -128, 127, 127);
        step_robot(0);
        step_robot(1);
        load_robot(2, 5, 5, 5, 5);
        step_robot(2);
        step_robot(2);
        load_robot(3, 10, 10, 11, 10);
        step_robot(3);
        load_robot(0, 20, 20, 30, 20);
        load_robot(1, 22, 20, 10, 20);
        step_robot(1);
        step_robot(0);
        load_robot(2, 19, 21, 0, 0);
        step_robot(0);
        load_robot(0, -128, 0, -120, 0);
        load_robot(1, -126, 0, -126, 5);
        load_robot(2, -128, 1, -128, 9);
        step_robot(0);
        step_robot(2);
        step_robot(1);
        step_robot(0);

        per_phase = RANDOM_ITEMS / PHASES;
        for (int p = 0; p < PHASES; p++)
        begin
            program_spacing(spacing_plan[p]);
            if (p == PHASES - 1 || p == 3)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            else
            begin
                tx_idle_pct = $urandom_range(10, 40);
                rx_idle_pct = $urandom_range(10, 40);
            end
            if (p == 0)
                hold_off = 1'b1;
            for (int n = 0; n < per_phase; n++)
            begin
                if (n % 60 == 0)
                begin
                    case ($urandom_range(3))
                        0: cx = -128;
                        1: cx = 127;
                        default: cx = int'($urandom_range(255)) - 128;
                    endcase
                    cy = ($urandom_range(3) == 0) ? -128 : int'($urandom_range(255)) - 128;
                end
                push_request(random_request(cx, cy));
            end
        end

        drain_requests();
        repeat (8) @(posedge clk);
        if (fleet.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
